FILE: sv/rdd_pkg.sv
package rdd_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    localparam logic [31:0] HDR_BYTES = 32'd12;
    localparam logic [19:0] ENT_BYTES = 20'd12;
    localparam logic [31:0] POS_MAX   = 32'hFFFF_FFFF;

    // header byte positions that close a field
    localparam logic [31:0] POS_MAGIC = 32'd3;
    localparam logic [31:0] POS_FSIZE = 32'd7;
    localparam logic [31:0] POS_COUNT = 32'd9;

    // byte within a directory entry that closes a field
    localparam logic [3:0] PART_TAG    = 4'd3;
    localparam logic [3:0] PART_INDEX  = 4'd7;
    localparam logic [3:0] PART_OFFSET = 4'd11;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_FIND = 1'b1;

    localparam logic RK_STATUS = 1'b0;
    localparam logic RK_FIND   = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] query_tag;
        logic [31:0] query_index;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic        decode_ok;
        logic [6:0]  entry_total;
        logic        found;
        logic [5:0]  entry_slot;
        logic [31:0] entry_offset;
        logic [31:0] entry_size;
    } t_out_item;

endpackage

FILE: sv/resource_directory_decoder.sv
// Resource directory decoder. File bytes stream in one beat per cycle, big-endian header
// (signature, file size, entry count) then 12-byte entries of tag, index and offset; the
// directory is kept in on-chip RAM. The last byte holds the input while the decode is
// closed and the status beat is handed to the output register. A find query walks the
// stored entries with one shared tag/index comparator against a RAM with registered read,
// a read state then a compare state per entry scanned. Either hand-over waits while the
// output register is full and stalled downstream. Input stall is high while a last byte
// or query is in progress; results sit in an output register, so plain file bytes are
// still taken while a result waits downstream. The magic word is written through
// i_cfg_we / i_cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce.
module resource_directory_decoder #(
    parameter int MAX_ENTRIES = rdd_pkg::MAX_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rdd_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rdd_pkg::t_out_item o_out_item
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [15:0] MAX16 = 16'(MAX_ENTRIES);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FIN  = 5'b00010,
        S_RD   = 5'b00100,
        S_CMP  = 5'b01000,
        S_ANS  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [31:0] r_magic;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_word, n_word;
    logic [31:0] r_fsize, n_fsize;
    logic [15:0] r_count, n_count;
    logic [19:0] r_tbl_end, n_tbl_end;
    logic [31:0] r_pend, n_pend;
    logic        r_failed, n_failed;
    logic        r_tbl_valid, n_tbl_valid;
    logic [3:0]  r_part, n_part;
    logic [AW-1:0] r_slot, n_slot;
    logic        r_tdone, n_tdone;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_index, n_index;
    logic [AW-1:0] r_idx, n_idx;
    logic [31:0] r_qtag, n_qtag;
    logic [31:0] r_qidx, n_qidx;
    rdd_pkg::t_out_item r_res, n_res;
    rdd_pkg::t_out_item r_out;
    logic        r_ovalid;

    logic        w_in_acc;
    logic        w_out_free;
    logic        w_load;
    logic        w_start;
    logic [31:0] w_cur_word;
    logic        w_cur_failed;
    logic [31:0] w_word_in;
    logic [31:0] w_sub_a;
    logic [32:0] w_diff;
    logic [19:0] w_tbl_end;
    logic        w_match;
    logic        w_ok;
    logic [31:0] w_idx32;

    logic          ent_we;
    logic [AW-1:0] ent_waddr;
    logic [95:0]   ent_wdata;
    logic [95:0]   ent_rdata;
    logic          siz_we;
    logic [AW-1:0] siz_waddr;
    logic [31:0]   siz_wdata;
    logic [31:0]   siz_rdata;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_ovalid || !i_out_stall;
    assign w_load     = (r_state == S_ANS) && w_out_free;

    // first byte of a file sees cleared decode state
    assign w_start      = (r_pos == '0);
    assign w_cur_word   = w_start ? '0 : r_word;
    assign w_cur_failed = w_start ? 1'b0 : r_failed;
    assign w_word_in    = {w_cur_word[23:0], i_in_item.data_byte};

    // shared subtractor: offset step during the table, last entry size on close
    assign w_sub_a = (r_state == S_FIN) ? r_fsize : w_word_in;
    assign w_diff  = {1'b0, w_sub_a} - {1'b0, r_pend};

    assign w_tbl_end = 20'(rdd_pkg::HDR_BYTES) + 20'(w_word_in[15:0]) * rdd_pkg::ENT_BYTES;

    assign w_match = (ent_rdata[95:64] == r_qtag) && (ent_rdata[63:32] == r_qidx);
    assign w_ok    = !r_failed && (r_pos >= rdd_pkg::HDR_BYTES) && (r_fsize == r_pos);
    assign w_idx32 = 32'(r_idx);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_word      = r_word;
        n_fsize     = r_fsize;
        n_count     = r_count;
        n_tbl_end   = r_tbl_end;
        n_pend      = r_pend;
        n_failed    = r_failed;
        n_tbl_valid = r_tbl_valid;
        n_part      = r_part;
        n_slot      = r_slot;
        n_tdone     = r_tdone;
        n_tag       = r_tag;
        n_index     = r_index;
        n_idx       = r_idx;
        n_qtag      = r_qtag;
        n_qidx      = r_qidx;
        n_res       = r_res;
        ent_we      = 1'b0;
        ent_waddr   = r_slot;
        ent_wdata   = {r_tag, r_index, w_word_in};
        siz_we      = 1'b0;
        siz_waddr   = r_slot - AW'(1);
        siz_wdata   = w_diff[31:0];

        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_in_item.operation == rdd_pkg::OP_FIND) begin
                    n_qtag = i_in_item.query_tag;
                    n_qidx = i_in_item.query_index;
                    n_idx  = '0;
                    n_res  = '0;
                    n_res.result_kind = rdd_pkg::RK_FIND;
                    n_state = r_tbl_valid ? S_RD : S_ANS;
                end else if (w_in_acc) begin
                    if (w_start) begin
                        n_word      = '0;
                        n_fsize     = '0;
                        n_count     = '0;
                        n_pend      = '0;
                        n_failed    = 1'b0;
                        n_tbl_valid = 1'b0;
                        n_part      = '0;
                        n_slot      = '0;
                        n_tdone     = 1'b0;
                    end
                    if (r_pos == rdd_pkg::POS_MAX) begin
                        n_failed = 1'b1;
                    end else begin
                        n_pos  = r_pos + 32'd1;
                        n_word = w_word_in;
                        if (!w_cur_failed) begin
                            if (r_pos == rdd_pkg::POS_MAGIC) begin
                                if (w_word_in != r_magic) begin
                                    n_failed = 1'b1;
                                end
                            end else if (r_pos == rdd_pkg::POS_FSIZE) begin
                                n_fsize = w_word_in;
                            end else if (r_pos == rdd_pkg::POS_COUNT) begin
                                n_count   = w_word_in[15:0];
                                n_tbl_end = w_tbl_end;
                                if (w_word_in[15:0] == '0 || w_word_in[15:0] > MAX16 ||
                                    32'(w_tbl_end) > r_fsize) begin
                                    n_failed = 1'b1;
                                end
                            end else if (r_pos >= rdd_pkg::HDR_BYTES && !r_tdone) begin
                                n_part = (r_part == rdd_pkg::PART_OFFSET) ? '0 : r_part + 4'd1;
                                if (r_part == rdd_pkg::PART_TAG) begin
                                    n_tag = w_word_in;
                                end else if (r_part == rdd_pkg::PART_INDEX) begin
                                    n_index = w_word_in;
                                end else if (r_part == rdd_pkg::PART_OFFSET) begin
                                    // w <= pending shows as a borrow or a zero difference
                                    if (32'(r_tbl_end) > w_word_in || w_word_in >= r_fsize ||
                                        (r_slot != '0 &&
                                         (w_diff[32] || w_diff[31:0] == '0))) begin
                                        n_failed = 1'b1;
                                    end else begin
                                        siz_we = (r_slot != '0);
                                        ent_we = 1'b1;
                                        n_pend = w_word_in;
                                    end
                                    if (16'(r_slot) == r_count - 16'd1) begin
                                        n_tdone = 1'b1;
                                    end else begin
                                        n_slot = r_slot + AW'(1);
                                    end
                                end
                            end
                        end
                    end
                    if (i_in_item.last_byte) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                siz_waddr   = AW'(r_count - 16'd1);
                siz_we      = w_ok;
                n_tbl_valid = w_ok;
                n_pos       = '0;
                n_res       = '0;
                n_res.result_kind = rdd_pkg::RK_STATUS;
                n_res.decode_ok   = w_ok;
                n_res.entry_total = w_ok ? r_count[6:0] : '0;
                n_state     = S_ANS;
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_match) begin
                    n_res.found        = 1'b1;
                    n_res.entry_slot   = w_idx32[5:0];
                    n_res.entry_offset = ent_rdata[31:0];
                    n_res.entry_size   = siz_rdata;
                    n_state = S_ANS;
                end else if (16'(r_idx) == r_count - 16'd1) begin
                    n_state = S_ANS;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_RD;
                end
            end
            S_ANS: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_magic     <= '0;
            r_pos       <= '0;
            r_failed    <= 1'b0;
            r_tbl_valid <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_failed    <= n_failed;
            r_tbl_valid <= n_tbl_valid;
            if (i_cfg_we) begin
                r_magic <= i_cfg_wdata;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_fsize   <= n_fsize;
        r_count   <= n_count;
        r_tbl_end <= n_tbl_end;
        r_pend    <= n_pend;
        r_part    <= n_part;
        r_slot    <= n_slot;
        r_tdone   <= n_tdone;
        r_tag     <= n_tag;
        r_index   <= n_index;
        r_idx     <= n_idx;
        r_qtag    <= n_qtag;
        r_qidx    <= n_qidx;
        r_res     <= n_res;
        if (w_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    // tag, index and offset of each entry
    rdd_ram #(
        .WIDTH (96),
        .DEPTH (MAX_ENTRIES)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (r_idx),
        .o_rdata (ent_rdata)
    );

    // payload sizes, filled one entry behind the offsets
    rdd_ram #(
        .WIDTH (32),
        .DEPTH (MAX_ENTRIES)
    ) u_siz_ram (
        .i_clk   (i_clk),
        .i_we    (siz_we),
        .i_waddr (siz_waddr),
        .i_wdata (siz_wdata),
        .i_raddr (r_idx),
        .o_rdata (siz_rdata)
    );

    a_cmp_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_RD))
        else $error("compare without a preceding RAM read");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_tbl_valid && (16'(r_idx) < r_count)))
        else $error("scan beyond the stored directory");

    a_status_matches_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ANS && r_res.result_kind == rdd_pkg::RK_STATUS)
            |-> (r_tbl_valid == r_res.decode_ok))
        else $error("status beat disagrees with table state");

endmodule

FILE: sv/rdd_ram.sv
module rdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: verif/rdd_checker.sv
module rdd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  rdd_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  rdd_pkg::t_out_item i_out_item,
    output int                 o_errors,
    output int                 o_outstanding
);

    localparam int SLOTS = rdd_pkg::MAX_ENTRIES_DEF;

    logic [31:0] magic;
    logic [31:0] byte_pos;
    logic [31:0] word_acc;
    logic [31:0] size_decl;
    logic [31:0] prev_offset;
    logic [15:0] dir_count;
    logic        broken;
    logic        dir_ready;
    logic [31:0] dir_tag    [SLOTS];
    logic [31:0] dir_index  [SLOTS];
    logic [31:0] dir_offset [SLOTS];
    logic [31:0] dir_size   [SLOTS];

    rdd_pkg::t_out_item answers_due [$];
    rdd_pkg::t_out_item predicted;
    rdd_pkg::t_out_item oldest;

    task automatic report_fault(input string msg);
        $display("[%0t] decoder check: %s", $time, msg);
        o_errors = o_errors + 1;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            report_fault($sformatf("%s expected %0h, got %0h", name, want, got));
        end
    endtask

    function automatic logic [31:0] dir_end();
        return rdd_pkg::HDR_BYTES + {16'd0, dir_count} * {12'd0, rdd_pkg::ENT_BYTES};
    endfunction

    task automatic store_entry_byte(input logic [31:0] pos);
        logic [31:0] rel;
        logic [31:0] slot;
        logic [31:0] part;
        rel  = pos - rdd_pkg::HDR_BYTES;
        slot = rel / {12'd0, rdd_pkg::ENT_BYTES};
        part = rel % {12'd0, rdd_pkg::ENT_BYTES};
        if (slot < {16'd0, dir_count} && slot < SLOTS) begin
            if (part == 32'(rdd_pkg::PART_TAG)) begin
                dir_tag[slot] = word_acc;
            end else if (part == 32'(rdd_pkg::PART_INDEX)) begin
                dir_index[slot] = word_acc;
            end else if (part == 32'(rdd_pkg::PART_OFFSET)) begin
                if (word_acc < dir_end() || word_acc >= size_decl ||
                    (slot != 0 && word_acc <= prev_offset)) begin
                    broken = 1'b1;
                end else begin
                    // previous entry's size is known once the next offset lands
                    if (slot != 0) dir_size[slot - 1] = word_acc - prev_offset;
                    dir_offset[slot] = word_acc;
                    prev_offset      = word_acc;
                end
            end
        end
    endtask

    task automatic take_file_byte(input logic [7:0] b);
        logic [31:0] pos;
        pos = byte_pos;
        if (pos == 0) begin
            word_acc    = '0;
            size_decl   = '0;
            dir_count   = '0;
            prev_offset = '0;
            broken      = 1'b0;
            dir_ready   = 1'b0;
        end
        if (pos == rdd_pkg::POS_MAX) begin
            broken = 1'b1;
        end else begin
            byte_pos = pos + 32'd1;
            word_acc = {word_acc[23:0], b};
            if (!broken) begin
                if (pos == rdd_pkg::POS_MAGIC) begin
                    if (word_acc != magic) broken = 1'b1;
                end else if (pos == rdd_pkg::POS_FSIZE) begin
                    size_decl = word_acc;
                end else if (pos == rdd_pkg::POS_COUNT) begin
                    dir_count = word_acc[15:0];
                    if (dir_count == 0 || dir_count > SLOTS || dir_end() > size_decl)
                        broken = 1'b1;
                end else if (pos >= rdd_pkg::HDR_BYTES) begin
                    store_entry_byte(pos);
                end
            end
        end
    endtask

    task automatic close_decode(output rdd_pkg::t_out_item res);
        logic ok;
        ok = !broken && byte_pos >= rdd_pkg::HDR_BYTES && size_decl == byte_pos &&
             dir_count >= 1 && dir_count <= SLOTS;
        if (ok) dir_size[dir_count - 1] = size_decl - dir_offset[dir_count - 1];
        dir_ready = ok;
        byte_pos  = '0;
        res             = '0;
        res.result_kind = rdd_pkg::RK_STATUS;
        res.decode_ok   = ok;
        res.entry_total = ok ? dir_count[6:0] : 7'd0;
    endtask

    task automatic find_entry(input logic [31:0] tag, input logic [31:0] idx,
                              output rdd_pkg::t_out_item res);
        logic hit;
        hit             = 1'b0;
        res             = '0;
        res.result_kind = rdd_pkg::RK_FIND;
        if (dir_ready) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!hit && i < dir_count && dir_tag[i] == tag && dir_index[i] == idx) begin
                    hit              = 1'b1;
                    res.found        = 1'b1;
                    res.entry_slot   = 6'(i);
                    res.entry_offset = dir_offset[i];
                    res.entry_size   = dir_size[i];
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors    = 0;
            magic       = '0;
            byte_pos    = '0;
            word_acc    = '0;
            size_decl   = '0;
            dir_count   = '0;
            prev_offset = '0;
            broken      = 1'b0;
            dir_ready   = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                dir_tag[i]    = '0;
                dir_index[i]  = '0;
                dir_offset[i] = '0;
                dir_size[i]   = '0;
            end
            answers_due.delete();
        end else begin
            if (i_cfg_we) magic = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.operation == rdd_pkg::OP_BYTE) begin
                    take_file_byte(i_in_item.data_byte);
                    if (i_in_item.last_byte) begin
                        close_decode(predicted);
                        answers_due.push_back(predicted);
                    end
                end else begin
                    find_entry(i_in_item.query_tag, i_in_item.query_index, predicted);
                    answers_due.push_back(predicted);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    report_fault("result beat with nothing expected");
                end else begin
                    oldest = answers_due.pop_front();
                    check_field("result_kind", 32'(oldest.result_kind),
                                32'(i_out_item.result_kind));
                    check_field("decode_ok", 32'(oldest.decode_ok),
                                32'(i_out_item.decode_ok));
                    check_field("entry_total", 32'(oldest.entry_total),
                                32'(i_out_item.entry_total));
                    check_field("found", 32'(oldest.found), 32'(i_out_item.found));
                    check_field("entry_slot", 32'(oldest.entry_slot),
                                32'(i_out_item.entry_slot));
                    check_field("entry_offset", oldest.entry_offset, i_out_item.entry_offset);
                    check_field("entry_size", oldest.entry_size, i_out_item.entry_size);
                end
            end
        end
        o_outstanding <= answers_due.size();
    end

endmodule

FILE: verif/resource_directory_decoder_test.sv
module resource_directory_decoder_test;

    // long enough for a find scan over a full directory
    localparam int SETTLE_CYCLES = 140;

    typedef enum int {
        FLAW_MAGIC,
        FLAW_SHORT,
        FLAW_CUT,
        FLAW_EXTRA,
        FLAW_COUNT_ZERO,
        FLAW_COUNT_HUGE,
        FLAW_COUNT_FAR,
        FLAW_OFFSET_LOW,
        FLAW_OFFSET_REPEAT,
        FLAW_OFFSET_HIGH,
        FLAW_BYTE
    } t_flaw;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [31:0]        i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    rdd_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_stall;
    rdd_pkg::t_out_item o_out_item;
    int                 fault_count;
    int                 outstanding;

    logic [31:0] tag_pool [4] = '{32'h494D_4147, 32'h534E_4420, 32'hFFFF_FFFF, 32'h0000_0000};
    logic [7:0]  file_q [$];
    logic [31:0] known_tag [$];
    logic [31:0] known_index [$];
    logic [31:0] magic_now;
    int          beats_sent;
    int          random_base;
    bit          quiet;

    resource_directory_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    rdd_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_item    (o_out_item),
        .o_errors      (fault_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("run limit reached");
        $display("Simulation FAILED");
        $finish;
    end

    // mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    initial begin
        i_out_stall = 1'b0;
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(20, 200)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat (idle_len() + 1) @(posedge i_clk);
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    task automatic put_beat(input rdd_pkg::t_in_item b);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic ask(input logic [31:0] tag, input logic [31:0] idx);
        rdd_pkg::t_in_item b;
        b.operation   = rdd_pkg::OP_FIND;
        b.data_byte   = 8'($urandom_range(0, 255));
        b.last_byte   = 1'($urandom_range(0, 1));
        b.query_tag   = tag;
        b.query_index = idx;
        put_beat(b);
    endtask

    task automatic ask_known();
        int k;
        int r;
        if (known_tag.size() == 0) begin
            ask($urandom, $urandom);
        end else begin
            k = $urandom_range(0, known_tag.size() - 1);
            r = $urandom_range(0, 5);
            if (r == 0) ask(known_tag[k], $urandom);
            else if (r == 1) ask($urandom, known_index[k]);
            else ask(known_tag[k], known_index[k]);
        end
    endtask

    task automatic ask_any();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) ask_known();
        else if (r < 8) ask(tag_pool[$urandom_range(0, 3)], $urandom_range(0, 2));
        else ask($urandom, $urandom);
    endtask

    task automatic put_word(input int at, input logic [31:0] w);
        file_q[at]     = w[31:24];
        file_q[at + 1] = w[23:16];
        file_q[at + 2] = w[15:8];
        file_q[at + 3] = w[7:0];
    endtask

    // well-formed file of n entries under the current signature
    task automatic build_file(input int n);
        int          tab_end;
        logic [31:0] off;
        logic [31:0] tag;
        logic [31:0] idx;
        logic [15:0] cnt;
        file_q.delete();
        known_tag.delete();
        known_index.delete();
        tab_end = 12 + 12 * n;
        repeat (tab_end) file_q.push_back(8'($urandom_range(0, 255)));
        put_word(0, magic_now);
        off = tab_end + $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            tag = ($urandom_range(0, 4) == 0) ? $urandom : tag_pool[$urandom_range(0, 3)];
            idx = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 2);
            put_word(12 + 12 * i, tag);
            put_word(16 + 12 * i, idx);
            put_word(20 + 12 * i, off);
            known_tag.push_back(tag);
            known_index.push_back(idx);
            off = off + $urandom_range(1, 4);
        end
        put_word(4, off);
        cnt       = 16'(n);
        file_q[8] = cnt[15:8];
        file_q[9] = cnt[7:0];
        while (file_q.size() < off) file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic spoil_file(input t_flaw f, input int n);
        int          k;
        int          j;
        logic [31:0] fsize;
        logic [15:0] cnt;
        fsize = file_q.size();
        k     = $urandom_range(0, n - 1);
        case (f)
            FLAW_MAGIC: begin
                j = $urandom_range(0, 3);
                file_q[j] = file_q[j] ^ (8'd1 << $urandom_range(0, 7));
            end
            FLAW_SHORT: begin
                j = $urandom_range(1, 11);
                while (file_q.size() > j) void'(file_q.pop_back());
            end
            FLAW_CUT: begin
                repeat ($urandom_range(1, 3)) void'(file_q.pop_back());
            end
            FLAW_EXTRA: begin
                repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(0, 255)));
            end
            FLAW_COUNT_ZERO: begin
                file_q[8] = 8'h00;
                file_q[9] = 8'h00;
            end
            FLAW_COUNT_HUGE: begin
                cnt       = 16'($urandom_range(rdd_pkg::MAX_ENTRIES_DEF + 1, 65535));
                file_q[8] = cnt[15:8];
                file_q[9] = cnt[7:0];
            end
            FLAW_COUNT_FAR: begin
                // full-size table overruns a small file
                cnt       = 16'(rdd_pkg::MAX_ENTRIES_DEF);
                file_q[8] = cnt[15:8];
                file_q[9] = cnt[7:0];
            end
            FLAW_OFFSET_LOW: begin
                put_word(20 + 12 * k, $urandom_range(0, 11 + 12 * n));
            end
            FLAW_OFFSET_REPEAT: begin
                if (k > 0) begin
                    for (int i = 0; i < 4; i++) file_q[20 + 12 * k + i] = file_q[8 + 12 * k + i];
                end else begin
                    put_word(20, fsize);
                end
            end
            FLAW_OFFSET_HIGH: begin
                put_word(20 + 12 * k, fsize + $urandom_range(0, 3));
            end
            FLAW_BYTE: begin
                file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_file();
        rdd_pkg::t_in_item b;
        for (int i = 0; i < file_q.size(); i++) begin
            // now and then a lookup lands mid-decode
            if ($urandom_range(0, 39) == 0) ask_any();
            b.operation   = rdd_pkg::OP_BYTE;
            b.data_byte   = file_q[i];
            b.last_byte   = (i == file_q.size() - 1);
            b.query_tag   = $urandom;
            b.query_index = $urandom;
            put_beat(b);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_magic(input logic [31:0] m);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        magic_now = m;
    endtask

    function automatic int pick_count();
        return ($urandom_range(0, 24) == 0) ? $urandom_range(5, rdd_pkg::MAX_ENTRIES_DEF)
                                            : $urandom_range(1, 4);
    endfunction

    task automatic stir();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = pick_count();
        if (r < 30) begin
            ask_any();
        end else if (r < 75) begin
            quiet = ($urandom_range(0, 3) == 0);
            build_file(n);
            send_file();
            quiet = 1'b0;
        end else if (r < 97) begin
            build_file(n);
            spoil_file(t_flaw'($urandom_range(0, FLAW_BYTE)), n);
            send_file();
        end else begin
            drain();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        magic_now    = '0;
        beats_sent   = 0;
        quiet        = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no directory decoded yet
        ask(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        set_magic(32'h5253_5243);
        quiet = 1'b1;
        build_file(1);
        file_q[10] = 8'h00;
        file_q[11] = 8'hFF;
        send_file();
        ask(known_tag[0], known_index[0]);
        ask(known_tag[0], ~known_index[0]);
        quiet = 1'b0;

        // duplicate key: first slot must win
        build_file(3);
        put_word(24, known_tag[0]);
        put_word(28, known_index[0]);
        known_tag[1]   = known_tag[0];
        known_index[1] = known_index[0];
        send_file();
        ask(known_tag[0], known_index[0]);
        ask(known_tag[2], known_index[2]);

        for (int f = 0; f <= FLAW_BYTE; f++) begin
            build_file(2);
            spoil_file(t_flaw'(f), 2);
            send_file();
            ask_any();
        end

        set_magic(32'h0000_0000);
        build_file(2);
        send_file();
        ask_known();

        set_magic(32'hFFFF_FFFF);
        build_file(1);
        send_file();
        ask_known();

        random_base = beats_sent;
        for (int ph = 1; ph <= 4; ph++) begin
            set_magic($urandom);
            while (beats_sent - random_base < 50 * ph) stir();
        end

        drain();
        if (fault_count == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
